>>> design/sra_pkg.sv
`default_nettype none
package sra_pkg;

	localparam int COL_W       = 6;
	localparam int DATA_W      = 32;
	localparam int VAL_W       = 48;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int FRAC_DROP   = 16;
	localparam int COLUMNS_DEF = 64;

	localparam logic FUNC_ACC   = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_SCAN,
		ST_LAG,
		ST_LAST
	} flush_state_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] idx;
	} scan_req_t;

	typedef struct packed {
		logic             hit;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} scan_rsp_t;

endpackage
`default_nettype wire

>>> design/sra_acc.sv
`default_nettype none
module sra_acc import sra_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     acc_en,
	input  wire logic [COL_W-1:0]         column,
	input  wire logic signed [DATA_W-1:0] a_value,
	input  wire logic signed [DATA_W-1:0] b_value,
	input  wire scan_req_t                scan_req,
	output logic                          pipe_busy,
	output scan_rsp_t                     scan_rsp
);

	localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic [VAL_W-1:0] mem [COLUMNS];
	logic [COLUMNS-1:0] occ_q;

	logic                     v_s1;
	logic [IDX_W-1:0]         col_s1;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;

	logic                     v_s2;
	logic [IDX_W-1:0]         col_s2;
	logic [VAL_W-1:0]         prod_s2;
	logic                     occ_s2;
	logic                     fwd_s2;
	logic [VAL_W-1:0]         fwd_val_s2;

	logic [VAL_W-1:0]         rd_q;
	logic                     hit_q;
	logic [COL_W-1:0]         hit_col_q;

	logic signed [PROD_W-1:0] prod;
	logic [IDX_W-1:0]         rd_addr;
	logic [VAL_W-1:0]         old_val;
	logic [VAL_W:0]           sum_wide;
	logic [VAL_W-1:0]         sum_sat;

	assign prod    = a_s1 * b_s1;
	assign rd_addr = scan_req.en ? scan_req.idx[IDX_W-1:0] : col_s1;

	always_comb begin
		if (fwd_s2) begin
			old_val = fwd_val_s2;
		end else if (occ_s2) begin
			old_val = rd_q;
		end else begin
			old_val = '0;
		end
		sum_wide = {old_val[VAL_W-1], old_val} + {prod_s2[VAL_W-1], prod_s2};
		if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
			sum_sat = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
			                          : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1     <= column[IDX_W-1:0];
		a_s1       <= a_value;
		b_s1       <= b_value;
		col_s2     <= col_s1;
		prod_s2    <= prod[PROD_W-1:FRAC_DROP];
		occ_s2     <= occ_q[col_s1];
		fwd_s2     <= v_s2 && (col_s2 == col_s1);
		fwd_val_s2 <= sum_sat;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mem[col_s2] <= sum_sat;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= scan_req.en && occ_q[rd_addr];
			if (scan_req.en) begin
				occ_q[rd_addr] <= 1'b0;
			end else if (v_s2) begin
				occ_q[col_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_col_q <= scan_req.idx;
	end

	assign pipe_busy      = v_s1 || v_s2;
	assign scan_rsp.hit   = hit_q;
	assign scan_rsp.col   = hit_col_q;
	assign scan_rsp.value = rd_q;

endmodule
`default_nettype wire

>>> design/sra_flush.sv
`default_nettype none
module sra_flush import sra_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              flush_go,
	input  wire logic              pipe_busy,
	input  wire scan_rsp_t         scan_rsp,
	output scan_req_t              scan_req,
	output logic                   busy,
	output logic                   result_valid,
	output logic [COL_W-1:0]       out_column,
	output logic signed [VAL_W-1:0] out_value,
	output logic                   empty_row,
	output logic                   last
);

	localparam logic [COL_W-1:0] LAST_IDX = COL_W'(COLUMNS - 1);

	flush_state_t state_q, state_d;

	logic [COL_W-1:0] scan_q;
	logic             pend_v_q;
	logic [COL_W-1:0] pend_col_q;
	logic [VAL_W-1:0] pend_val_q;

	logic             emit;
	logic             emit_last;
	logic             emit_empty;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (flush_go) state_d = ST_DRAIN;
			ST_DRAIN: if (!pipe_busy) state_d = ST_SCAN;
			ST_SCAN:  if (scan_q == LAST_IDX) state_d = ST_LAG;
			ST_LAG:   state_d = ST_LAST;
			ST_LAST:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		unique case (state_q) inside
			ST_SCAN, ST_LAG: begin
				emit = scan_rsp.hit && pend_v_q;
			end
			ST_LAST: begin
				emit       = 1'b1;
				emit_last  = 1'b1;
				emit_empty = !pend_v_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign scan_req.en  = (state_q == ST_SCAN);
	assign scan_req.idx = scan_q;
	assign busy         = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (state_q == ST_DRAIN) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + COL_W'(1);
			end
			if (state_q == ST_LAST) begin
				pend_v_q <= 1'b0;
			end else if ((state_q == ST_SCAN || state_q == ST_LAG) && scan_rsp.hit) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN || state_q == ST_LAG) && scan_rsp.hit) begin
			pend_col_q <= scan_rsp.col;
			pend_val_q <= scan_rsp.value;
		end
		if (emit) begin
			out_column <= emit_empty ? '0 : pend_col_q;
			out_value  <= emit_empty ? '0 : pend_val_q;
			empty_row  <= emit_empty;
			last       <= emit_last;
		end
	end

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && empty_row |-> last)
		else $error("empty row result without last");

	a_last_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> state_q == ST_IDLE)
		else $error("last result while flush still running");

	a_scan_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !pipe_busy)
		else $error("scan overlaps product pipeline");

	a_no_result_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> !result_valid)
		else $error("result during drain");

endmodule
`default_nettype wire

>>> design/sparse_row_accumulator.sv
// Channel   Ports                                        Handshake
// in        func, column, a_value, b_value               start && !busy
// out       out_column, out_value, empty_row, last       result_valid, one cycle
//
// Product items are taken one per cycle while no flush holds busy; each passes
// through the multiply and read-modify-write pipeline, with forwarding between
// neighbors. A flush holds busy to drain the pipeline, scan one column of the
// occupancy map per cycle emitting occupied columns, then emit the final item.
// Reset clears the occupancy map at once; accumulator memory needs no sweep.
// Results cannot be stalled and appear as one-cycle strobes.
`default_nettype none
module sparse_row_accumulator import sra_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     func,
	input  wire logic [COL_W-1:0]         column,
	input  wire logic signed [DATA_W-1:0] a_value,
	input  wire logic signed [DATA_W-1:0] b_value,
	output logic                          result_valid,
	output logic [COL_W-1:0]              out_column,
	output logic signed [VAL_W-1:0]       out_value,
	output logic                          empty_row,
	output logic                          last
);

	logic      accept;
	logic      acc_en;
	logic      flush_go;
	logic      pipe_busy;
	scan_req_t scan_req;
	scan_rsp_t scan_rsp;

	assign accept   = start && !busy;
	assign acc_en   = accept && (func == FUNC_ACC)
	                  && ({1'b0, column} < (COL_W + 1)'(COLUMNS));
	assign flush_go = accept && (func == FUNC_FLUSH);

	sra_acc #(
		.COLUMNS(COLUMNS)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_en    (acc_en),
		.column    (column),
		.a_value   (a_value),
		.b_value   (b_value),
		.scan_req  (scan_req),
		.pipe_busy (pipe_busy),
		.scan_rsp  (scan_rsp)
	);

	sra_flush #(
		.COLUMNS(COLUMNS)
	) u_flush (
		.clk          (clk),
		.arst_n       (arst_n),
		.flush_go     (flush_go),
		.pipe_busy    (pipe_busy),
		.scan_rsp     (scan_rsp),
		.scan_req     (scan_req),
		.busy         (busy),
		.result_valid (result_valid),
		.out_column   (out_column),
		.out_value    (out_value),
		.empty_row    (empty_row),
		.last         (last)
	);

endmodule
`default_nettype wire

>>> sim/sparse_row_accumulator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sparse_row_accumulator_tb;
	import sra_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int RANDOM_ITEMS   = 170;
	localparam int QUIET_TAIL     = 140;

	typedef struct packed {
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		logic                    empty;
		logic                    last;
	} nonzero_t;

	typedef struct packed {
		logic              func;
		logic [COL_W-1:0]  col;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              typed;
		nonzero_t          exp;
	} stim_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     func;
	logic [COL_W-1:0]         column;
	logic signed [DATA_W-1:0] a_value;
	logic signed [DATA_W-1:0] b_value;
	logic                     result_valid;
	logic [COL_W-1:0]         out_column;
	logic signed [VAL_W-1:0]  out_value;
	logic                     empty_row;
	logic                     last;

	logic     typed_now;
	nonzero_t typed_exp;

	logic signed [VAL_W-1:0] col_sum [COLUMNS_DEF];
	logic                    col_used [COLUMNS_DEF];
	nonzero_t                row_results [$];
	stim_t                   directed [$];
	int                      mismatches;
	int                      quiet_cycles;

	sparse_row_accumulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.column       (column),
		.a_value      (a_value),
		.b_value      (b_value),
		.result_valid (result_valid),
		.out_column   (out_column),
		.out_value    (out_value),
		.empty_row    (empty_row),
		.last         (last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void fold_product(input logic [COL_W-1:0] c,
			input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
		logic signed [PROD_W-1:0] full;
		logic signed [PROD_W-1:0] q;
		logic [VAL_W:0]           s;
		full = a * b;
		q = full >>> FRAC_DROP;
		s = {col_sum[c][VAL_W-1], col_sum[c]} + q[VAL_W:0];
		if (s[VAL_W] != s[VAL_W-1])
			col_sum[c] = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			col_sum[c] = s[VAL_W-1:0];
		col_used[c] = 1'b1;
	endfunction

	function automatic void flush_row(input bit keep);
		nonzero_t held;
		bit       have;
		have = 1'b0;
		held = '0;
		for (int k = 0; k < COLUMNS_DEF; k++) begin
			if (col_used[k]) begin
				if (have && keep)
					row_results.push_back(held);
				held.col = COL_W'(k);
				held.value = col_sum[k];
				held.empty = 1'b0;
				held.last = 1'b0;
				have = 1'b1;
				col_sum[k] = '0;
				col_used[k] = 1'b0;
			end
		end
		if (!have) begin
			held.empty = 1'b1;
		end
		held.last = 1'b1;
		if (keep)
			row_results.push_back(held);
	endfunction

	function automatic stim_t row(input logic f, input int c,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input int typed, input nonzero_t exp);
		stim_t s;
		s.func = f;
		s.col = COL_W'(c);
		s.a = a;
		s.b = b;
		s.typed = (typed != 0);
		s.exp = exp;
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		logic [DATA_W-1:0] w;
		case ($urandom_range(0, 9)) inside
			[0:3]: w = $urandom;
			[4:7]: w = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			8: begin
				case ($urandom_range(0, 3))
					0: w = 32'h8000_0000;
					1: w = 32'h7FFF_FFFF;
					2: w = 32'hFFFF_FFFF;
					default: w = '0;
				endcase
			end
			default: w = $urandom_range(0, 16'hFFFF);
		endcase
		return w;
	endfunction

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (func == FUNC_ACC) begin
				fold_product(column, a_value, b_value);
			end else begin
				if (typed_now)
					row_results.push_back(typed_exp);
				flush_row(!typed_now);
			end
		end
	end

	always @(posedge clk) begin
		nonzero_t want;
		if (arst_n && result_valid) begin
			if (row_results.size() == 0) begin
				$error("unexpected item: out_column %0d out_value %0d", out_column, out_value);
				mismatches++;
			end else begin
				want = row_results.pop_front();
				if (out_column !== want.col) begin
					$error("out_column: expected %0d, got %0d", want.col, out_column);
					mismatches++;
				end
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", want.value, out_value);
					mismatches++;
				end
				if (empty_row !== want.empty) begin
					$error("empty_row: expected %0d, got %0d", want.empty, empty_row);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sparse_row_accumulator regression: fail");
			$finish;
		end
	end

	task automatic send(input stim_t s);
		@(negedge clk);
		start <= 1'b1;
		func <= s.func;
		column <= s.col;
		a_value <= s.a;
		b_value <= s.b;
		typed_now <= s.typed;
		typed_exp <= s.exp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic maybe_idle(input bit quiet);
		if (!quiet && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 15));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (row_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int       sent;
		int       kind;
		int       nprod;
		bit       calm;
		bit       quiet;
		logic [COL_W-1:0] base;
		logic [COL_W-1:0] c;
		nonzero_t none;

		none = '0;
		sent = 0;
		mismatches = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ACC;
		column = '0;
		a_value = '0;
		b_value = '0;
		typed_now = 1'b0;
		typed_exp = '0;
		for (int k = 0; k < COLUMNS_DEF; k++) begin
			col_sum[k] = '0;
			col_used[k] = 1'b0;
		end

		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(0), 48'sh0, 1'b1, 1'b1}));
		directed.push_back(row(FUNC_ACC, 0, 32'h0001_0000, 32'h0001_0000, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(0), 48'sh1_0000, 1'b0, 1'b1}));
		directed.push_back(row(FUNC_ACC, 63, 32'h8000_0000, 32'h8000_0000, 0, none));
		directed.push_back(row(FUNC_ACC, 63, 32'h8000_0000, 32'h8000_0000, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(63), 48'sh7FFF_FFFF_FFFF, 1'b0, 1'b1}));
		directed.push_back(row(FUNC_ACC, 5, 32'h8000_0000, 32'h7FFF_FFFF, 0, none));
		directed.push_back(row(FUNC_ACC, 5, 32'h8000_0000, 32'h7FFF_FFFF, 0, none));
		directed.push_back(row(FUNC_ACC, 5, 32'h8000_0000, 32'h7FFF_FFFF, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(5), 48'sh8000_0000_0000, 1'b0, 1'b1}));
		directed.push_back(row(FUNC_ACC, 1, 32'hFFFF_FFFF, 32'h0000_0001, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(1), 48'shFFFF_FFFF_FFFF, 1'b0, 1'b1}));
		directed.push_back(row(FUNC_ACC, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none));
		directed.push_back(row(FUNC_ACC, 40, 32'h0002_8000, 32'hFFFE_0000, 0, none));
		directed.push_back(row(FUNC_ACC, 33, 32'h0000_0000, 32'h1234_5678, 0, none));
		directed.push_back(row(FUNC_ACC, 2, 32'h8000_0000, 32'h0001_0000, 0, none));
		directed.push_back(row(FUNC_ACC, 0, 32'h0000_0001, 32'h0000_0001, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 1,
			'{COL_W'(0), 48'sh0, 1'b1, 1'b1}));
		directed.push_back(row(FUNC_ACC, 62, 32'hFFFF_8000, 32'h0000_8000, 0, none));
		directed.push_back(row(FUNC_ACC, 62, 32'h0000_0001, 32'hFFFF_FFFF, 0, none));
		directed.push_back(row(FUNC_FLUSH, 0, 0, 0, 0, none));

		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			maybe_idle(1'b0);
			send(directed[i]);
		end
		wait_drained();

		for (int k = 0; k < COLUMNS_DEF; k++)
			send(row(FUNC_ACC, COLUMNS_DEF - 1 - k, pick_word(), pick_word(), 0, none));
		send(row(FUNC_FLUSH, 0, 0, 0, 0, none));
		sent = directed.size() + COLUMNS_DEF + 1;

		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			calm = ($urandom_range(0, 3) == 0);
			base = COL_W'($urandom_range(0, 63));
			if (kind <= 6)
				nprod = $urandom_range(1, 10);
			else if (kind == 7)
				nprod = $urandom_range(20, 40);
			else if (kind == 8)
				nprod = 0;
			else
				nprod = $urandom_range(1, 4);
			for (int k = 0; k < nprod; k++) begin
				quiet = calm || sent >= QUIET_TAIL;
				c = (kind == 7) ? COL_W'($urandom_range(0, 63)) : base + COL_W'($urandom_range(0, 7));
				maybe_idle(quiet);
				send(row(FUNC_ACC, int'(c), pick_word(), pick_word(), 0, none));
				sent++;
			end
			if (kind != 9) begin
				maybe_idle(calm || sent >= QUIET_TAIL);
				send(row(FUNC_FLUSH, 0, 0, 0, 0, none));
				sent++;
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
		end
		send(row(FUNC_FLUSH, 0, 0, 0, 0, none));

		@(negedge clk);
		start <= 1'b0;
		while (row_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("sparse_row_accumulator regression: pass");
		else
			$display("sparse_row_accumulator regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
design/sra_pkg.sv
design/sra_acc.sv
design/sra_flush.sv
design/sparse_row_accumulator.sv
sim/sparse_row_accumulator_tb.sv
